// ===== hdl/multi_slot_tween_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tween engine
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TWEEN_ENGINE_MACROS_SVH
`define MULTI_SLOT_TWEEN_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked property, held off during reset
`define MSTE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tween engine assertion failed");
// clocked property, checked during reset too
`define MSTE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tween engine assertion failed");
`else
`define MSTE_ASSERT(lbl, clk, rstn, prop)
`define MSTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/mste_pkg.sv =====
// ----------------------------------------------------------------------------
// mste_pkg
// Shared types and codes of the tween engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mste_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        KIND_START_REPLY = 2'd0,
        KIND_STOP_ACK    = 2'd1,
        KIND_UPDATE      = 2'd2,
        KIND_TICK_DONE   = 2'd3
    } kind_t;

    localparam logic [1:0] EASE_IN  = 2'd1;
    localparam logic [1:0] EASE_OUT = 2'd2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        act_t         op;
        logic [31:0]  start_value;
        logic [31:0]  end_value;
        logic [15:0]  tween_len;
        logic [1:0]   ease_kind;
        logic         notify;
        logic [2:0]   slot_select;
        logic [15:0]  tick_step;
    } cmd_t;

endpackage

// ===== hdl/mste_front.sv =====
// ----------------------------------------------------------------------------
// mste_front
// Unpacks input transfers into commands; drops the unused action code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mste_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,
    input  logic [mste_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output mste_pkg::cmd_t                 cmd
);
    import mste_pkg::*;

    always_comb begin
        cmd.op          = act_t'(s_tuser);
        cmd.start_value = s_tdata[31:0];
        cmd.end_value   = s_tdata[63:32];
        cmd.tween_len   = s_tdata[79:64];
        cmd.ease_kind   = s_tdata[81:80];
        cmd.notify      = s_tdata[82];
        cmd.slot_select = s_tdata[85:83];
        cmd.tick_step   = s_tdata[101:86];
    end

    // unused code is consumed without reaching the queue
    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid && (act_t'(s_tuser) != ACT_NONE);

endmodule

// ===== hdl/mste_fifo.sv =====
// ----------------------------------------------------------------------------
// mste_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mste_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/mste_back.sv =====
// ----------------------------------------------------------------------------
// mste_back
// Slot table, tick sequencer with shared divider and multiplier, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_slot_tween_engine_macros.svh"
module mste_back #(
    parameter int SLOTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  mste_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [1:0]                      m_tuser,
    output logic [mste_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import mste_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SCAN = 8'b0000_0010,
        ST_DIV  = 8'b0000_0100,
        ST_SQR  = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_VAL  = 8'b0010_0000,
        ST_EMIT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // slot table
    logic [SLOTS-1:0] active_reg, active_next;
    logic [31:0]      start_reg [SLOTS];
    logic [31:0]      end_reg   [SLOTS];
    logic [15:0]      dur_reg   [SLOTS];
    logic [15:0]      el_reg    [SLOTS];
    logic [1:0]       ease_reg  [SLOTS];
    logic             ntf_reg   [SLOTS];

    // tick datapath
    logic [IW-1:0]      idx_reg, idx_next;
    logic [15:0]        delta_reg, delta_next;
    logic               any_reg, any_next;
    logic [16:0]        rem_reg, rem_next;
    logic [15:0]        t_reg, t_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [16:0]        f_reg, f_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [50:0] prod_reg, prod_next;
    logic [31:0]        val_reg, val_next;
    logic               fin_reg, fin_next;

    // result register
    logic        ov_reg, ov_next;
    kind_t       ok_reg, ok_next;
    logic [2:0]  os_reg, os_next;
    logic        og_reg, og_next;
    logic [31:0] oval_reg, oval_next;
    logic        ofin_reg, ofin_next;
    logic        oany_reg, oany_next;
    logic        olast_reg, olast_next;

    logic             out_free, push;
    logic             got_found;
    logic [IW-1:0]    got_idx;
    logic [SLOTS-1:0] stop_mask, tick_alive;
    logic [16:0]      sum, r2, sq_in;
    logic [15:0]      e_sat;
    logic [33:0]      sq;
    logic signed [50:0] adj, q;
    logic             write_start, write_el;

    assign out_free = !ov_reg || m_tready;

    always_comb begin
        got_found = 1'b0;
        got_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!active_reg[j]) begin
                got_found = 1'b1;
                got_idx   = IW'(j);
            end
        end
    end

    always_comb begin
        logic [16:0] s;
        logic [15:0] e;
        for (int j = 0; j < SLOTS; j++) begin
            stop_mask[j] = (32'(cmd.slot_select) == 32'(j));
            s = {1'b0, el_reg[j]} + {1'b0, cmd.tick_step};
            e = s[16] ? 16'hFFFF : s[15:0];
            tick_alive[j] = active_reg[j] && (e < dur_reg[j]);
        end
    end

    // datapath for the slot at the walk index
    assign sum   = {1'b0, el_reg[idx_reg]} + {1'b0, delta_reg};
    assign e_sat = sum[16] ? 16'hFFFF : sum[15:0];
    assign r2    = {rem_reg[15:0], 1'b0};
    assign sq_in = (ease_reg[idx_reg] == EASE_OUT) ? (17'h10000 - {1'b0, t_reg})
                                                   : {1'b0, t_reg};
    assign sq    = sq_in * sq_in;
    assign adj   = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
    assign q     = adj >>> 16;

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        delta_next  = delta_reg;
        any_next    = any_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        f_next      = f_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        val_next    = val_reg;
        fin_next    = fin_reg;
        ov_next     = ov_reg && !m_tready;
        ok_next     = ok_reg;
        os_next     = os_reg;
        og_next     = og_reg;
        oval_next   = oval_reg;
        ofin_next   = ofin_reg;
        oany_next   = oany_reg;
        olast_next  = olast_reg;
        cmd_pop     = 1'b0;
        push        = 1'b0;
        write_start = 1'b0;
        write_el    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.op)
                        ACT_START: begin
                            if (out_free) begin
                                cmd_pop    = 1'b1;
                                push       = 1'b1;
                                ok_next    = KIND_START_REPLY;
                                os_next    = got_found ? 3'(got_idx) : 3'd0;
                                og_next    = got_found;
                                oval_next  = '0;
                                ofin_next  = 1'b0;
                                oany_next  = 1'b1;
                                olast_next = 1'b1;
                                if (got_found) begin
                                    write_start          = 1'b1;
                                    active_next[got_idx] = 1'b1;
                                end
                            end
                        end
                        ACT_STOP: begin
                            if (out_free) begin
                                cmd_pop     = 1'b1;
                                push        = 1'b1;
                                active_next = active_reg & ~stop_mask;
                                ok_next     = KIND_STOP_ACK;
                                os_next     = cmd.slot_select;
                                og_next     = 1'b0;
                                oval_next   = '0;
                                ofin_next   = 1'b0;
                                oany_next   = |(active_reg & ~stop_mask);
                                olast_next  = 1'b1;
                            end
                        end
                        ACT_TICK: begin
                            cmd_pop    = 1'b1;
                            delta_next = cmd.tick_step;
                            any_next   = |tick_alive;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!active_reg[idx_reg]) begin
                    state_next = (idx_reg == LAST_IDX) ? ST_DONE : ST_SCAN;
                    idx_next   = idx_reg + IW'(1);
                end else begin
                    write_el  = 1'b1;
                    diff_next = $signed({end_reg[idx_reg][31], end_reg[idx_reg]})
                              - $signed({start_reg[idx_reg][31], start_reg[idx_reg]});
                    if (e_sat >= dur_reg[idx_reg]) begin
                        active_next[idx_reg] = 1'b0;
                        val_next   = end_reg[idx_reg];
                        fin_next   = 1'b1;
                        if (ntf_reg[idx_reg]) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = (idx_reg == LAST_IDX) ? ST_DONE : ST_SCAN;
                            idx_next   = idx_reg + IW'(1);
                        end
                    end else begin
                        fin_next   = 1'b0;
                        rem_next   = {1'b0, e_sat};
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // restoring step, one quotient bit a cycle
                if (r2 >= {1'b0, dur_reg[idx_reg]}) begin
                    rem_next = r2 - {1'b0, dur_reg[idx_reg]};
                    t_next   = {t_reg[14:0], 1'b1};
                end else begin
                    rem_next = r2;
                    t_next   = {t_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (ease_reg[idx_reg] == EASE_IN) begin
                    f_next = sq[32:16];
                end else if (ease_reg[idx_reg] == EASE_OUT) begin
                    f_next = 17'h10000 - sq[32:16];
                end else begin
                    f_next = {1'b0, t_reg};
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = 51'(diff_reg * $signed({1'b0, f_reg}));
                state_next = ST_VAL;
            end
            ST_VAL: begin
                val_next = start_reg[idx_reg] + q[31:0];
                if (ntf_reg[idx_reg]) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = (idx_reg == LAST_IDX) ? ST_DONE : ST_SCAN;
                    idx_next   = idx_reg + IW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    push       = 1'b1;
                    ok_next    = KIND_UPDATE;
                    os_next    = 3'(idx_reg);
                    og_next    = 1'b0;
                    oval_next  = val_reg;
                    ofin_next  = fin_reg;
                    oany_next  = any_reg;
                    olast_next = 1'b0;
                    state_next = (idx_reg == LAST_IDX) ? ST_DONE : ST_SCAN;
                    idx_next   = idx_reg + IW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    push       = 1'b1;
                    ok_next    = KIND_TICK_DONE;
                    os_next    = '0;
                    og_next    = 1'b0;
                    oval_next  = '0;
                    ofin_next  = 1'b0;
                    oany_next  = any_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (push) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            ov_reg     <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg <= delta_next;
        any_reg   <= any_next;
        rem_reg   <= rem_next;
        t_reg     <= t_next;
        cnt_reg   <= cnt_next;
        f_reg     <= f_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        val_reg   <= val_next;
        fin_reg   <= fin_next;
        ok_reg    <= ok_next;
        os_reg    <= os_next;
        og_reg    <= og_next;
        oval_reg  <= oval_next;
        ofin_reg  <= ofin_next;
        oany_reg  <= oany_next;
        olast_reg <= olast_next;
        if (write_start) begin
            start_reg[got_idx] <= cmd.start_value;
            end_reg[got_idx]   <= cmd.end_value;
            dur_reg[got_idx]   <= cmd.tween_len;
            el_reg[got_idx]    <= '0;
            ease_reg[got_idx]  <= cmd.ease_kind;
            ntf_reg[got_idx]   <= cmd.notify;
        end
        if (write_el) begin
            el_reg[idx_reg] <= e_sat;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = ok_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, oany_reg, ofin_reg, oval_reg, og_reg, os_reg};

    // divider remainder stays below the divisor
    `MSTE_ASSERT(a_rem_bound, aclk, aresetn,
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, dur_reg[idx_reg]}))
    // a result is never pushed over one that is still held
    `MSTE_ASSERT(a_no_overwrite, aclk, aresetn, push |-> out_free)
    // commands are taken only between ticks
    `MSTE_ASSERT(a_pop_idle, aclk, aresetn, cmd_pop |-> (state_reg == ST_IDLE))
    // the walk only visits active slots for the math states
    `MSTE_ASSERT(a_walk_active, aclk, aresetn,
        (state_reg == ST_SQR) |-> active_reg[idx_reg])

endmodule

// ===== hdl/multi_slot_tween_engine.sv =====
// ----------------------------------------------------------------------------
// multi_slot_tween_engine
// Eased tween table: start, stop and tick actions over SLOTS slots.
// ----------------------------------------------------------------------------
//  channel   dir  tuser          tdata                                    tlast
//  s_        in   action[1:0]    start,end,duration,ease,notify,slot,delta  -
//  m_        out  kind[1:0]      slot,granted,value,finished,any_active     last
//
//  Start and stop: handled by the back end in idle once at the queue head and
//  the result register is free; the reply is registered after the command queue.
//  Tick: scan, 16 bit-serial divider steps, square, scale and sum for each active
//  slot that keeps running; a slot not active or finishing takes only the scan;
//  each update result adds an emit step, and a tick-done result ends the walk.
//  Reset: synchronous, active low; clears the active marks and queue state.
//  Stalls: the two-entry queue lets input transfers land while a tick runs;
//  the result register holds while m_tready is low and the back end waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multi_slot_tween_engine #(
    parameter int SLOTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action
    input  logic [1:0]                      s_tuser,
    // start_value[31:0] end_value[63:32] tween_len[79:64] ease_kind[81:80]
    // notify[82] slot_select[85:83] tick_step[101:86], rest zero
    input  logic [mste_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // kind
    output logic [1:0]                      m_tuser,
    // slot[2:0] granted[3] value[35:4] finished[36] any_active[37], rest zero
    output logic [mste_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import mste_pkg::*;

    cmd_t cmd_in, cmd_out;
    logic in_valid, in_ready, q_valid, q_pop;

    // front: unpack and classify
    mste_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd_valid (in_valid),
        .cmd_ready (in_ready),
        .cmd       (cmd_in)
    );

    // queue decouples the sides
    mste_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (cmd_in),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (cmd_out)
    );

    // back: slot table and tick sequencer
    mste_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (cmd_out),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
